// ===== rtl/dcpt_pkg.sv =====
// shared types and constants for the delta correlating prefetcher
`timescale 1ns / 1ps
package dcpt_pkg;
  localparam int TableEntries = 16;
  localparam int DeltaSlots = 16;
  localparam int MaxResults = 16;
  localparam int SlotW = $clog2(TableEntries);
  localparam int RingW = $clog2(DeltaSlots);
  localparam int ResW = $clog2(MaxResults);
  localparam int DeltaW = 11;
  localparam int DeltaModW = 10;
  localparam int DeltaMod = 1 << DeltaModW;
  localparam int RankW = SlotW;

  typedef logic signed [DeltaW-1:0] delta_t;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_SEARCH = 11'b00000000010,
    ST_FETCH  = 11'b00000000100,
    ST_ALLOC  = 11'b00000001000,
    ST_CLEAR  = 11'b00000010000,
    ST_PUSH   = 11'b00000100000,
    ST_MATCH  = 11'b00001000000,
    ST_SCAN   = 11'b00010000000,
    ST_EMIT   = 11'b00100000000,
    ST_NONE   = 11'b01000000000,
    ST_WAIT   = 11'b10000000000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture request
    logic search_step; // compare one table slot
    logic alloc;       // take over lru slot
    logic clear_step;  // clear one ring entry
    logic push;        // store delta, promote slot
    logic fetch_step;  // copy one ring entry out of the ring memory
    logic match_step;  // compare one ring pair
    logic scan_step;   // walk one candidate for suppression
    logic emit_step;   // advance to next candidate
    logic none;        // load a no-candidate result
    logic out_load;    // load candidate result
    logic finish;      // write last prefetch
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic search_done;
    logic hit;
    logic clear_done;
    logic zero_delta;
    logic fetch_done;
    logic match_done;
    logic found;
    logic scan_done;
    logic emit_done;
    logic emit_empty;
  } stat_t;
endpackage

// ===== rtl/dcpt_ctrl.sv =====
// controller state machine for the delta correlating prefetcher
`timescale 1ns / 1ps
module dcpt_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  dcpt_pkg::stat_t st,
  output dcpt_pkg::cmd_t cmd
);
  import dcpt_pkg::*;

  state_t state, state_next;
  logic out_valid_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    out_valid_next = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    in_ready = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search_step = 1'b1;
        if (st.hit) state_next = ST_PUSH;
        else if (st.search_done) state_next = ST_ALLOC;
      end
      ST_FETCH: begin
        cmd.fetch_step = 1'b1;
        if (st.fetch_done) state_next = ST_MATCH;
      end
      ST_ALLOC: begin
        cmd.alloc = 1'b1;
        state_next = ST_CLEAR;
      end
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_done) state_next = ST_NONE;
      end
      ST_PUSH: begin
        cmd.push = 1'b1;
        state_next = st.zero_delta ? ST_NONE : ST_FETCH;
      end
      ST_MATCH: begin
        cmd.match_step = 1'b1;
        if (st.found) state_next = ST_SCAN;
        else if (st.match_done) state_next = ST_NONE;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_done) state_next = st.emit_empty ? ST_NONE : ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_next) begin
          cmd.out_load = 1'b1;
          out_valid_next = 1'b1;
          if (st.emit_done) begin
            cmd.finish = 1'b1;
            state_next = ST_WAIT;
          end else begin
            cmd.emit_step = 1'b1;
          end
        end
      end
      ST_NONE: begin
        if (!out_valid_next) begin
          cmd.none = 1'b1;
          out_valid_next = 1'b1;
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!out_valid_next) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !out_valid)
    else $error("request taken while result pending");
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
`endif
endmodule

// ===== rtl/dcpt_dp.sv =====
// table, delta ring and candidate datapath for the delta correlating prefetcher
`timescale 1ns / 1ps
module dcpt_dp (
  input  logic clk,
  input  logic rst,
  input  dcpt_pkg::cmd_t cmd,
  output dcpt_pkg::stat_t st,
  input  logic [31:0] access_pc,
  input  logic [31:0] miss_addr,
  output logic [31:0] prefetch_addr,
  output logic has_prefetch,
  output logic last_of_run
);
  import dcpt_pkg::*;

  logic [TableEntries-1:0] slot_valid;
  logic [31:0] slot_pc [TableEntries];
  logic [31:0] slot_last_address [TableEntries];
  logic [31:0] slot_last_prefetch [TableEntries];
  logic [RingW-1:0] slot_ring_head [TableEntries];
  logic [RankW-1:0] slot_rank [TableEntries];
  delta_t ring_mem [TableEntries*DeltaSlots];
  delta_t ring_rd;
  delta_t lane [DeltaSlots];

  logic [31:0] req_pc, req_addr, sum, first_sum, lastpf, lastaddr;
  logic [SlotW-1:0] sidx, sel, lru;
  logic [RingW:0] cnt, fcnt;
  logic [RingW-1:0] rhead, ip, pp, np, first_p;
  logic [ResW-1:0] ecnt;
  logic found_any;
  logic [31:0] diff, mag;
  logic [DeltaModW-1:0] rem;
  delta_t delta;
  logic [31:0] cand;

  assign diff = req_addr - lastaddr;
  assign mag = diff[31] ? (~diff + 32'd1) : diff;
  assign rem = mag[DeltaModW-1:0];
  assign delta = diff[31] ? -delta_t'(rem) : delta_t'(rem);
  assign cand = sum + 32'(signed'(lane[pp + RingW'(1)]));

  always_comb begin
    lru = '0;
    for (int k = 0; k < TableEntries; k++)
      if (slot_rank[k] == RankW'(TableEntries - 1)) lru = SlotW'(k);
  end

  assign st.hit = cmd.search_step && slot_valid[sidx] && slot_pc[sidx] == req_pc;
  assign st.search_done = (sidx == SlotW'(TableEntries - 1));
  assign st.clear_done = (ip == RingW'(DeltaSlots - 1));
  assign st.zero_delta = (delta == '0);
  assign st.fetch_done = (fcnt == (RingW + 1)'(DeltaSlots));
  assign st.found = (lane[ip - RingW'(1)] == lane[np - RingW'(1)]) && (lane[ip] == lane[np]);
  assign st.match_done = (cnt == (RingW + 1)'(DeltaSlots - 3));
  assign st.scan_done = (pp == np);
  assign st.emit_done = (pp + RingW'(1) == np) || (ecnt == ResW'(MaxResults - 1));
  assign st.emit_empty = found_any && (first_p == np);

  // ring memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.clear_step) ring_mem[{sel, ip}] <= '0;
    else if (cmd.push && !st.zero_delta) ring_mem[{sel, rhead}] <= delta;
    if (cmd.fetch_step) ring_rd <= ring_mem[{sel, fcnt[RingW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      for (int k = 0; k < TableEntries; k++) begin
        slot_rank[k] <= RankW'(k);
        slot_ring_head[k] <= '0;
      end
    end else begin
      if (cmd.load) begin
        req_pc <= access_pc;
        req_addr <= miss_addr;
        sidx <= '0;
      end
      if (cmd.search_step) begin
        sel <= sidx;
        sidx <= sidx + SlotW'(1);
        lastaddr <= slot_last_address[sidx];
        lastpf <= slot_last_prefetch[sidx];
        rhead <= slot_ring_head[sidx];
      end
      if (cmd.alloc) begin
        sel <= lru;
        slot_valid[lru] <= 1'b1;
        slot_pc[lru] <= req_pc;
        slot_last_address[lru] <= req_addr;
        slot_last_prefetch[lru] <= '0;
        slot_ring_head[lru] <= '0;
        for (int k = 0; k < TableEntries; k++)
          if (slot_rank[k] < slot_rank[lru]) slot_rank[k] <= slot_rank[k] + RankW'(1);
        slot_rank[lru] <= '0;
        ip <= '0;
      end
      if (cmd.clear_step) ip <= ip + RingW'(1);
      if (cmd.push) begin
        for (int k = 0; k < TableEntries; k++)
          if (slot_rank[k] < slot_rank[sel]) slot_rank[k] <= slot_rank[k] + RankW'(1);
        slot_rank[sel] <= '0;
        if (delta != '0) begin
          slot_ring_head[sel] <= rhead + RingW'(1);
          slot_last_address[sel] <= req_addr;
          np <= rhead;
          ip <= rhead - RingW'(1);
          cnt <= '0;
          fcnt <= '0;
        end
      end
      if (cmd.fetch_step) begin
        fcnt <= fcnt + (RingW + 1)'(1);
        if (fcnt != '0) lane[fcnt[RingW-1:0] - RingW'(1)] <= ring_rd;
      end
      if (cmd.match_step) begin
        if (st.found) begin
          pp <= ip;
          sum <= req_addr;
          found_any <= 1'b0;
        end else begin
          ip <= ip - RingW'(1);
          cnt <= cnt + (RingW + 1)'(1);
        end
      end
      if (cmd.scan_step) begin
        if (!st.scan_done) begin
          pp <= pp + RingW'(1);
          sum <= cand;
          if (cand == lastpf) begin
            found_any <= 1'b1;
            first_p <= pp + RingW'(1);
            first_sum <= cand;
          end
        end else begin
          pp <= found_any ? first_p : ip;
          sum <= found_any ? first_sum : req_addr;
          ecnt <= '0;
        end
      end
      if (cmd.out_load) begin
        prefetch_addr <= cand;
        has_prefetch <= 1'b1;
        last_of_run <= st.emit_done;
      end
      if (cmd.emit_step) begin
        pp <= pp + RingW'(1);
        sum <= cand;
        ecnt <= ecnt + ResW'(1);
      end
      if (cmd.finish) slot_last_prefetch[sel] <= cand;
      if (cmd.none) begin
        prefetch_addr <= '0;
        has_prefetch <= 1'b0;
        last_of_run <= 1'b1;
      end
    end
  end
endmodule

// ===== rtl/delta_correlating_prefetcher_core.sv =====
// top level of the delta correlating prefetcher
`timescale 1ns / 1ps
// miss requests arrive on access_pc/miss_addr with in_valid/in_ready.
// results leave on prefetch_addr/has_prefetch/last_of_run with
// out_valid/out_ready, one or more per request, last_of_run on the final.
// one request is in work at a time; in_ready is high only when idle.
// the table is searched one slot a cycle, the selected ring is copied
// out of the ring memory one entry a cycle, matched one pair a cycle
// and walked once for suppression.
// each further result is loaded in the same cycle as the one before it
// is accepted. the next request can be taken in the cycle after the
// final result is accepted.
// reset empties the table and puts the lru order in identity; a slot's
// ring is cleared when the slot is taken over.
// a stalled receiver holds the result register and the walk waits.
module delta_correlating_prefetcher_core (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [31:0] access_pc,
  input  logic [31:0] miss_addr,
  output logic out_valid,
  input  logic out_ready,
  output logic [31:0] prefetch_addr,
  output logic has_prefetch,
  output logic last_of_run
);
  import dcpt_pkg::*;
  cmd_t cmd;
  stat_t st;

  dcpt_ctrl u_ctrl (.clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .st, .cmd);
  dcpt_dp u_dp (.clk, .rst, .cmd, .st, .access_pc, .miss_addr,
    .prefetch_addr, .has_prefetch, .last_of_run);
endmodule
